// ===== sv/spq_pkg.sv =====
// Package for the stable priority queue: widths, codes, cell types.
// No dependencies; every other file of the block imports it.
package spq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VALUE_W      = 32;
  localparam int PRIO_W       = 4;
  localparam int STATUS_W     = 3;

  localparam logic [PRIO_W-1:0] PRIORITY_LIMIT = 4'd10;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REMOVED      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY        = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL         = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_PRIORITY = 3'd4;

  // One slot of the sorted row.
  typedef struct packed {
    logic                      vld;
    logic [PRIO_W-1:0]         prio;
    logic signed [VALUE_W-1:0] value;
  } entry_t;

  // Command broadcast to every cell in the row.
  typedef struct packed {
    logic                      ins;
    logic                      rem;
    logic [PRIO_W-1:0]         prio;
    logic signed [VALUE_W-1:0] value;
  } cell_cmd_t;

endpackage

// ===== sv/spq_cmd_if.sv =====
// Command channel of the stable priority queue: valid/ready plus request payload.
// Depends on spq_pkg for field widths.
interface spq_cmd_if;
  import spq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic signed [VALUE_W-1:0] value;
  logic [PRIO_W-1:0]         priority_req;

  modport source (output valid, operation, value, priority_req, input ready);
  modport sink   (input valid, operation, value, priority_req, output ready);
endinterface

// ===== sv/spq_rsp_if.sv =====
// Response channel of the stable priority queue: valid/ready plus result payload.
// Depends on spq_pkg for field widths.
interface spq_rsp_if;
  import spq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] out_value;
  logic [PRIO_W-1:0]         out_priority;
  logic [STATUS_W-1:0]       status;

  modport source (output valid, out_value, out_priority, status, input ready);
  modport sink   (input valid, out_value, out_priority, status, output ready);
endinterface

// ===== sv/stable_priority_queue.sv =====
// Stable priority queue built as a sorted row of shift cells, head at cell 0.
// The result of a beat is registered onto the response channel in the next cycle.
// One beat per cycle unless rsp stalls; cells shift or hold one step per beat.
// Reset clears the cell valid bits, the entry count and the response valid flag.
// Depends on spq_pkg, spq_cmd_if, spq_rsp_if and spq_cell.
module stable_priority_queue #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input logic          clk,
  input logic          rst,
  spq_cmd_if.sink      cmd,
  spq_rsp_if.source    rsp
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  entry_t               cell_q [CAPACITY];
  logic [CAPACITY-1:0]  cell_ahead;
  cell_cmd_t            cell_cmd;

  logic [CNT_W-1:0]     cnt;
  logic [CNT_W-1:0]     cnt_next;

  logic                      rsp_valid;
  logic signed [VALUE_W-1:0] rsp_value;
  logic [PRIO_W-1:0]         rsp_priority;
  logic [STATUS_W-1:0]       rsp_status;

  logic cmd_fire;
  logic is_ins;
  logic bad_prio;
  logic full;
  logic empty;
  logic ins_ok;
  logic rem_ok;

  assign cmd.ready = !rsp_valid || rsp.ready;
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign is_ins    = (cmd.operation == OP_INSERT);
  assign bad_prio  = (cmd.priority_req >= PRIORITY_LIMIT);
  assign full      = (cnt == CNT_W'(CAPACITY));
  assign empty     = (cnt == '0);
  assign ins_ok    = cmd_fire && is_ins && !bad_prio && !full;
  assign rem_ok    = cmd_fire && !is_ins && !empty;

  assign cell_cmd.ins   = ins_ok;
  assign cell_cmd.rem   = rem_ok;
  assign cell_cmd.prio  = cmd.priority_req;
  assign cell_cmd.value = cmd.value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    logic   left_b;

    if (i == 0) begin : g_head
      assign left_e = '0;
      assign left_b = 1'b1;
    end else begin : g_mid
      assign left_e = cell_q[i-1];
      assign left_b = cell_ahead[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_body
      assign right_e = cell_q[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cell_cmd),
      .left_entry  (left_e),
      .left_ahead  (left_b),
      .right_entry (right_e),
      .entry       (cell_q[i]),
      .ahead       (cell_ahead[i])
    );
  end

  always_comb begin
    cnt_next = cnt;
    if (ins_ok) begin
      cnt_next = cnt + 1'b1;
    end else if (rem_ok) begin
      cnt_next = cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd_fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      rsp_value    <= '0;
      rsp_priority <= '0;
      if (is_ins) begin
        if (bad_prio) begin
          rsp_status <= ST_BAD_PRIORITY;
        end else if (full) begin
          rsp_status <= ST_FULL;
        end else begin
          rsp_status <= ST_INSERTED;
        end
      end else if (empty) begin
        rsp_status <= ST_EMPTY;
      end else begin
        rsp_status   <= ST_REMOVED;
        rsp_value    <= cell_q[0].value;
        rsp_priority <= cell_q[0].prio;
      end
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.out_value    = rsp_value;
  assign rsp.out_priority = rsp_priority;
  assign rsp.status       = rsp_status;

  // The count and the head cell must agree on emptiness.
  a_count_head: assert property (@(posedge clk) disable iff (rst)
    (cnt == '0) == !cell_q[0].vld)
    else $error("entry count disagrees with head cell");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    ins_ok |=> (cnt == $past(cnt) + 1'b1))
    else $error("accepted insert did not grow the count");

  for (genvar i = 0; i < CAPACITY - 1; i++) begin : g_chk
    a_sorted: assert property (@(posedge clk) disable iff (rst)
      cell_q[i+1].vld |-> (cell_q[i].vld && (cell_q[i].prio <= cell_q[i+1].prio)))
      else $error("cell row lost its priority order");
  end

endmodule

// ===== sv/spq_cell.sv =====
// One slot of the sorted shift row: keeps, takes the new entry, or shifts.
// Depends on spq_pkg for entry_t and cell_cmd_t.
module spq_cell (
  input  logic               clk,
  input  logic               rst,
  input  spq_pkg::cell_cmd_t cmd,
  input  spq_pkg::entry_t    left_entry,
  input  logic               left_ahead,
  input  spq_pkg::entry_t    right_entry,
  output spq_pkg::entry_t    entry,
  output logic               ahead
);
  import spq_pkg::*;

  entry_t entry_next;

  // Equal priorities stay ahead of the newcomer, which keeps the order stable.
  assign ahead = entry.vld && (entry.prio <= cmd.prio);

  always_comb begin
    entry_next = entry;
    if (cmd.rem) begin
      entry_next = right_entry;
    end else if (cmd.ins && !ahead) begin
      if (left_ahead) begin
        entry_next.vld   = 1'b1;
        entry_next.prio  = cmd.prio;
        entry_next.value = cmd.value;
      end else begin
        entry_next = left_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.vld <= 1'b0;
    end else begin
      entry.vld <= entry_next.vld;
    end
    entry.prio  <= entry_next.prio;
    entry.value <= entry_next.value;
  end

endmodule

// ===== dv/tb_stable_priority_queue.sv =====
`timescale 1ns / 1ps
// Testbench for stable_priority_queue: a directed table, then random command
// bursts, with every response checked against its typed result or a predictor of the queue.
// Depends on spq_pkg, spq_cmd_if, spq_rsp_if and the block itself.
module tb_stable_priority_queue;
  import spq_pkg::*;

  localparam int QUEUE_DEPTH  = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 950;
  localparam int CYCLE_LIMIT  = 300000;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]         prio;
    logic [STATUS_W-1:0]       status;
  } queue_result_t;

  typedef struct packed {
    logic                      op;
    logic signed [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]         prio;
    logic                      typed;
    queue_result_t             result;
  } script_row_t;

  localparam queue_result_t NO_RESULT = '{value: '0, prio: '0, status: ST_INSERTED};
  localparam queue_result_t GOT_EMPTY = '{value: '0, prio: '0, status: ST_EMPTY};
  localparam queue_result_t GOT_FULL  = '{value: '0, prio: '0, status: ST_FULL};
  localparam queue_result_t GOT_BAD   = '{value: '0, prio: '0, status: ST_BAD_PRIORITY};

  // Typed rows carry their own result; the rest are predicted.
  script_row_t script [26] = '{
    '{OP_REMOVE, 32'sd0,           4'd0,  1'b1, GOT_EMPTY},
    '{OP_INSERT, 32'sd5,           4'd15, 1'b1, GOT_BAD},
    '{OP_INSERT, 32'sd7,           4'd10, 1'b1, GOT_BAD},
    '{OP_INSERT, 32'sh7fffffff,    4'd9,  1'b1, NO_RESULT},
    '{OP_INSERT, 32'sh80000000,    4'd0,  1'b1, NO_RESULT},
    '{OP_INSERT, 32'sd0,           4'd9,  1'b1, NO_RESULT},
    '{OP_REMOVE, 32'sd0,           4'd0,  1'b0, NO_RESULT},
    '{OP_REMOVE, -32'sd1,          4'd15, 1'b0, NO_RESULT},
    '{OP_INSERT, 32'sd101,         4'd3,  1'b1, NO_RESULT},
    '{OP_INSERT, 32'sd102,         4'd1,  1'b1, NO_RESULT},
    '{OP_INSERT, 32'sd103,         4'd3,  1'b1, NO_RESULT},
    '{OP_INSERT, -32'sd104,        4'd0,  1'b1, NO_RESULT},
    '{OP_INSERT, 32'sd105,         4'd1,  1'b1, NO_RESULT},
    '{OP_INSERT, 32'sh55555555,    4'd5,  1'b1, NO_RESULT},
    '{OP_INSERT, 32'shaaaaaaaa,    4'd5,  1'b1, NO_RESULT},
    '{OP_INSERT, 32'sd108,         4'd0,  1'b1, NO_RESULT},
    '{OP_INSERT, 32'sd109,         4'd8,  1'b1, NO_RESULT},
    '{OP_INSERT, 32'sd110,         4'd2,  1'b1, NO_RESULT},
    '{OP_INSERT, 32'sd111,         4'd3,  1'b1, NO_RESULT},
    '{OP_INSERT, 32'sd112,         4'd7,  1'b1, NO_RESULT},
    '{OP_INSERT, 32'sd113,         4'd6,  1'b1, NO_RESULT},
    '{OP_INSERT, 32'sd114,         4'd4,  1'b1, NO_RESULT},
    '{OP_INSERT, 32'sd115,         4'd1,  1'b1, NO_RESULT},
    '{OP_INSERT, 32'sd116,         4'd2,  1'b1, GOT_FULL},
    '{OP_INSERT, 32'sd117,         4'd11, 1'b1, GOT_BAD},
    '{OP_REMOVE, 32'sd0,           4'd0,  1'b0, NO_RESULT}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  spq_cmd_if cmd ();
  spq_rsp_if rsp ();

  stable_priority_queue #(.CAPACITY(QUEUE_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .rsp(rsp)
  );

  always #5 clk = ~clk;

  // Predictor state: entries in arrival order.
  logic signed [VALUE_W-1:0] held_values [$];
  logic [PRIO_W-1:0]         held_prios [$];
  queue_result_t             pending_results [$];

  int errors = 0;
  int cycle_count = 0;
  int burst_left = 0;
  logic [5:0] stall_phase = '0;
  logic [1:0] stall_mode = '0;
  queue_result_t oldest;

  function automatic queue_result_t predict_outcome(input logic op,
                                                    input logic signed [VALUE_W-1:0] value,
                                                    input logic [PRIO_W-1:0] prio);
    queue_result_t res;
    int pick;
    res = NO_RESULT;
    if (op == OP_INSERT) begin
      if (prio >= PRIORITY_LIMIT) begin
        res.status = ST_BAD_PRIORITY;
      end else if (held_values.size() >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        held_values.push_back(value);
        held_prios.push_back(prio);
      end
    end else if (held_values.size() == 0) begin
      res.status = ST_EMPTY;
    end else begin
      // Strict compare keeps the earliest entry among equal priorities.
      pick = 0;
      for (int i = 1; i < held_prios.size(); i++) begin
        if (held_prios[i] < held_prios[pick]) pick = i;
      end
      res.value  = held_values[pick];
      res.prio   = held_prios[pick];
      res.status = ST_REMOVED;
      held_values.delete(pick);
      held_prios.delete(pick);
    end
    return res;
  endfunction

  task automatic issue_command(input logic op, input logic signed [VALUE_W-1:0] value,
                               input logic [PRIO_W-1:0] prio, input logic typed,
                               input queue_result_t typed_result);
    int gap;
    queue_result_t predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        cmd.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    cmd.valid        <= 1'b1;
    cmd.operation    <= op;
    cmd.value        <= value;
    cmd.priority_req <= prio;
    do @(posedge clk); while (!cmd.ready);
    // Beat accepted at this edge.
    predicted = predict_outcome(op, value, prio);
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  initial begin
    int insert_pct;
    bit narrow;
    logic [PRIO_W-1:0] prio_base;
    logic op;
    logic signed [VALUE_W-1:0] value;
    logic [PRIO_W-1:0] prio;

    cmd.valid        = 1'b0;
    cmd.operation    = OP_INSERT;
    cmd.value        = '0;
    cmd.priority_req = '0;
    insert_pct       = 50;
    narrow           = 1'b0;
    prio_base        = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      issue_command(script[i].op, script[i].value, script[i].prio, script[i].typed,
                    script[i].result);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Shift the insert/remove mix so the queue swings between full and empty.
      if (n % 50 == 0) begin
        case ($urandom_range(0, 3))
          0: insert_pct = 15;
          1: insert_pct = 50;
          2: insert_pct = 85;
          default: insert_pct = 97;
        endcase
        narrow    = ($urandom_range(0, 1) == 1);
        prio_base = PRIO_W'($urandom_range(0, 8));
      end
      op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
      case ($urandom_range(0, 9))
        0: value = 32'sh7fffffff;
        1: value = 32'sh80000000;
        2: value = $urandom_range(0, 15);
        default: value = $urandom;
      endcase
      if ($urandom_range(0, 99) < 8) prio = PRIO_W'($urandom_range(10, 15));
      else if (narrow) prio = prio_base + PRIO_W'($urandom_range(0, 1));
      else prio = PRIO_W'($urandom_range(0, 9));
      issue_command(op, value, prio, 1'b0, NO_RESULT);
    end
    cmd.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Response sink: stall pattern changes whenever the stall phase counter wraps.
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1'b1;
    if (stall_phase == '0) stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0: rsp.ready <= 1'b1;
      2'd1: rsp.ready <= ($urandom_range(0, 3) != 0);
      2'd2: rsp.ready <= ($urandom_range(0, 3) == 0);
      default: rsp.ready <= (stall_phase[1:0] == 2'd3);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected response: expected none, got value %0d priority %0d status %0d",
                 $time, rsp.out_value, rsp.out_priority, rsp.status);
        errors++;
      end else begin
        oldest = pending_results.pop_front();
        if (rsp.status !== oldest.status) begin
          $display("%0t: status mismatch: expected %0d, got %0d",
                   $time, oldest.status, rsp.status);
          errors++;
        end
        if (rsp.out_value !== oldest.value) begin
          $display("%0t: out_value mismatch: expected %0d, got %0d",
                   $time, oldest.value, rsp.out_value);
          errors++;
        end
        if (rsp.out_priority !== oldest.prio) begin
          $display("%0t: out_priority mismatch: expected %0d, got %0d",
                   $time, oldest.prio, rsp.out_priority);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
sv/spq_pkg.sv
sv/spq_cmd_if.sv
sv/spq_rsp_if.sv
sv/spq_cell.sv
sv/stable_priority_queue.sv
dv/tb_stable_priority_queue.sv
